/* rtl/stereo_crossfade_mixer_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef STEREO_CROSSFADE_MIXER_CORE_ASSERT_SVH
`define STEREO_CROSSFADE_MIXER_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SCM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("scm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scm assertion failed");

`endif

/* rtl/scm_pkg.sv */
package scm_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int FADER_STEPS  = 1024;

   localparam int GAIN_W = 16;
   localparam int VOL_W  = 16;
   localparam int POS_W  = $clog2(FADER_STEPS + 1);
   localparam int PEAK_W = SAMPLE_WIDTH;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);

   // datapath widths: two Q1.15 products plus send return summed, then one volume product
   localparam int ACC_W   = SAMPLE_WIDTH + GAIN_W + 2;
   localparam int MUL_B_W = VOL_W + 1;
   localparam int PROD_W  = ACC_W + MUL_B_W;

   localparam int SEND_SHIFT = 15;
   localparam int MAIN_SHIFT = 30;
   localparam int CUE_SHIFT  = 15;

   // stream word layouts
   localparam int IN_BITS    = 8 * SAMPLE_WIDTH + 1;
   localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_BITS   = 4 * SAMPLE_WIDTH + PEAK_W;
   localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

   // config port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_MAIN_VOL      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CUE_VOL       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_XFADE_ENABLE  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_XFADE_POS     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_SWAP     = CSR_IDX_W'(4);

   localparam logic [VOL_W-1:0] MAIN_VOL_RST      = VOL_W'(32768);
   localparam logic [VOL_W-1:0] CUE_VOL_RST       = VOL_W'(32768);
   localparam logic [POS_W-1:0] XFADE_POS_RST     = POS_W'(512);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] deck_a_left;
      logic signed [SAMPLE_WIDTH-1:0] deck_a_right;
      logic signed [SAMPLE_WIDTH-1:0] deck_b_left;
      logic signed [SAMPLE_WIDTH-1:0] deck_b_right;
      logic signed [SAMPLE_WIDTH-1:0] cue_in_left;
      logic signed [SAMPLE_WIDTH-1:0] cue_in_right;
      logic signed [SAMPLE_WIDTH-1:0] send_return_left;
      logic signed [SAMPLE_WIDTH-1:0] send_return_right;
      logic                           clear_peak;
      logic [GAIN_W-1:0]              gain_a;
      logic [GAIN_W-1:0]              gain_b;
      logic [VOL_W-1:0]               main_vol;
      logic [VOL_W-1:0]               cue_vol;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef logic [GAIN_W-1:0] gain_table_type [0:FADER_STEPS];

   // Taylor sine through x^13 in Q2.30, rounded to Q1.15 and capped at unity
   function automatic logic [GAIN_W-1:0] quarter_sine(input int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      x    = (HALF_PI_Q30 * 64'(k) + 64'(FADER_STEPS / 2)) / FADER_STEPS;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            default: term = term / 64'd156;
         endcase
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd16384) >> 15;
      return (r > 64'(UNITY_GAIN)) ? UNITY_GAIN : GAIN_W'(r);
   endfunction

   function automatic gain_table_type build_gain_table();
      gain_table_type t;
      for (int k = 0; k <= FADER_STEPS; k++) begin
         t[k] = quarter_sine(k);
      end
      return t;
   endfunction

   localparam gain_table_type GAIN_TABLE = build_gain_table();

   localparam logic signed [PROD_W:0] SAT_HI =
      (PROD_W + 1)'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [PROD_W:0] SAT_LO = -SAT_HI - (PROD_W + 1)'(1);

   // round half up at the chosen scale, then clamp to the sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      input logic signed [PROD_W-1:0] p,
      input logic                     main_scale);
      logic signed [PROD_W:0] t;
      logic signed [PROD_W:0] r;
      if (main_scale) begin
         t = {p[PROD_W-1], p} + (PROD_W + 1)'(longint'(1) <<< (MAIN_SHIFT - 1));
         r = t >>> MAIN_SHIFT;
      end else begin
         t = {p[PROD_W-1], p} + (PROD_W + 1)'(longint'(1) <<< (CUE_SHIFT - 1));
         r = t >>> CUE_SHIFT;
      end
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   // the negative limit maps to 2^(SAMPLE_WIDTH-1), which still fits unsigned
   function automatic logic [PEAK_W-1:0] magnitude(
      input logic signed [SAMPLE_WIDTH-1:0] v);
      return v[SAMPLE_WIDTH-1] ? PEAK_W'(~v + SAMPLE_WIDTH'(1)) : PEAK_W'(v);
   endfunction

endpackage

/* rtl/scm_front.sv */
module scm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [scm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [scm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [scm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [scm_pkg::IN_DATA_W-1:0]     req_tdata,
   input  scm_pkg::queue_status_type         q_status,
   output logic                              push,
   output scm_pkg::item_type                 push_item
);

   localparam int SW = scm_pkg::SAMPLE_WIDTH;

   logic [scm_pkg::VOL_W-1:0]  master_ff, master_in;
   logic [scm_pkg::VOL_W-1:0]  cue_ff, cue_in;
   logic                       xf_en_ff, xf_en_in;
   logic [scm_pkg::POS_W-1:0]  xf_pos_ff, xf_pos_in;
   logic                       swap_ff, swap_in;
   logic [scm_pkg::GAIN_W-1:0] rom_left_ff, rom_left_in;
   logic [scm_pkg::GAIN_W-1:0] rom_right_ff, rom_right_in;

   logic                          csr_wr;
   logic [scm_pkg::CSR_IDX_W-1:0] csr_idx;
   logic [scm_pkg::POS_W-1:0]     pos_clamp;
   logic [scm_pkg::GAIN_W-1:0]    gain_a, gain_b;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[scm_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      master_in = master_ff;
      cue_in    = cue_ff;
      xf_en_in  = xf_en_ff;
      xf_pos_in = xf_pos_ff;
      swap_in   = swap_ff;
      if (csr_wr) begin
         case (csr_idx)
            scm_pkg::REG_MAIN_VOL:      master_in = csr_pwdata[scm_pkg::VOL_W-1:0];
            scm_pkg::REG_CUE_VOL:       cue_in    = csr_pwdata[scm_pkg::VOL_W-1:0];
            scm_pkg::REG_XFADE_ENABLE:  xf_en_in  = csr_pwdata[0];
            scm_pkg::REG_XFADE_POS:     xf_pos_in = csr_pwdata[scm_pkg::POS_W-1:0];
            scm_pkg::REG_SIDE_SWAP:     swap_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         scm_pkg::REG_MAIN_VOL:      csr_prdata = scm_pkg::CSR_DATA_W'(master_ff);
         scm_pkg::REG_CUE_VOL:       csr_prdata = scm_pkg::CSR_DATA_W'(cue_ff);
         scm_pkg::REG_XFADE_ENABLE:  csr_prdata = scm_pkg::CSR_DATA_W'(xf_en_ff);
         scm_pkg::REG_XFADE_POS:     csr_prdata = scm_pkg::CSR_DATA_W'(xf_pos_ff);
         scm_pkg::REG_SIDE_SWAP:     csr_prdata = scm_pkg::CSR_DATA_W'(swap_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // positions past the end of the fader act as full right side; the table
   // is read from the next position so its output lands with the register
   assign pos_clamp = (xf_pos_in > scm_pkg::POS_W'(scm_pkg::FADER_STEPS)) ?
                      scm_pkg::POS_W'(scm_pkg::FADER_STEPS) : xf_pos_in;

   assign rom_left_in  = scm_pkg::GAIN_TABLE[scm_pkg::POS_W'(scm_pkg::FADER_STEPS) - pos_clamp];
   assign rom_right_in = scm_pkg::GAIN_TABLE[pos_clamp];

   always_comb begin
      if (xf_en_ff) begin
         gain_a = swap_ff ? rom_right_ff : rom_left_ff;
         gain_b = swap_ff ? rom_left_ff : rom_right_ff;
      end else begin
         gain_a = scm_pkg::UNITY_GAIN;
         gain_b = scm_pkg::UNITY_GAIN;
      end
   end

   assign req_tready = ~q_status.full;
   assign push       = req_tvalid & req_tready;

   always_comb begin
      push_item.deck_a_left       = req_tdata[0*SW +: SW];
      push_item.deck_a_right      = req_tdata[1*SW +: SW];
      push_item.deck_b_left       = req_tdata[2*SW +: SW];
      push_item.deck_b_right      = req_tdata[3*SW +: SW];
      push_item.cue_in_left       = req_tdata[4*SW +: SW];
      push_item.cue_in_right      = req_tdata[5*SW +: SW];
      push_item.send_return_left  = req_tdata[6*SW +: SW];
      push_item.send_return_right = req_tdata[7*SW +: SW];
      push_item.clear_peak        = req_tdata[8*SW];
      push_item.gain_a            = gain_a;
      push_item.gain_b            = gain_b;
      push_item.main_vol          = master_ff;
      push_item.cue_vol           = cue_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= scm_pkg::MAIN_VOL_RST;
         cue_ff    <= scm_pkg::CUE_VOL_RST;
         xf_en_ff  <= 1'b0;
         xf_pos_ff <= scm_pkg::XFADE_POS_RST;
         swap_ff   <= 1'b0;
      end else begin
         master_ff <= master_in;
         cue_ff    <= cue_in;
         xf_en_ff  <= xf_en_in;
         xf_pos_ff <= xf_pos_in;
         swap_ff   <= swap_in;
      end
   end

   // registered gain table reads, refreshed every cycle
   always_ff @(posedge clock) begin
      rom_left_ff  <= rom_left_in;
      rom_right_ff <= rom_right_in;
   end

endmodule

/* rtl/scm_queue.sv */
module scm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  scm_pkg::item_type          push_item,
   input  logic                       pop,
   output scm_pkg::item_type          head_item,
   output scm_pkg::queue_status_type  q_status
);

   scm_pkg::item_type mem_ff [scm_pkg::QUEUE_DEPTH];

   logic [scm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [scm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [scm_pkg::QPTR_W:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == (scm_pkg::QPTR_W + 1)'(scm_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_item      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == scm_pkg::QPTR_W'(scm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + scm_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == scm_pkg::QPTR_W'(scm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + scm_pkg::QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + (scm_pkg::QPTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (scm_pkg::QPTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/scm_back.sv */
module scm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  scm_pkg::queue_status_type         q_status,
   input  scm_pkg::item_type                 head_item,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scm_pkg::OUT_DATA_W-1:0]    rsp_tdata
);

   localparam int SW     = scm_pkg::SAMPLE_WIDTH;
   localparam int ACC_W  = scm_pkg::ACC_W;
   localparam int PROD_W = scm_pkg::PROD_W;
   localparam int MB_W   = scm_pkg::MUL_B_W;

   // step codes: step n issues product n and retires product n-1
   localparam logic [3:0] ST_A_L   = 4'd0;
   localparam logic [3:0] ST_B_L   = 4'd1;
   localparam logic [3:0] ST_A_R   = 4'd2;
   localparam logic [3:0] ST_B_R   = 4'd3;
   localparam logic [3:0] ST_MIX_L = 4'd4;
   localparam logic [3:0] ST_MIX_R = 4'd5;
   localparam logic [3:0] ST_CUE_L = 4'd6;
   localparam logic [3:0] ST_CUE_R = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   scm_pkg::item_type item_ff;

   logic                           busy_ff, busy_in;
   logic [3:0]                     step_ff, step_in;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [ACC_W-1:0]        acc_l_ff, acc_r_ff;
   logic signed [SW-1:0]           main_l_ff, main_r_ff, cue_l_ff;
   logic [scm_pkg::PEAK_W-1:0]     peak_hold_ff, peak_hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [scm_pkg::OUT_DATA_W-1:0] rsp_data_ff;

   logic signed [ACC_W-1:0]    mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]   mul_out;
   logic signed [ACC_W-1:0]    send_l, send_r;
   logic signed [SW-1:0]       rounded;
   logic                       out_free, start, finish, issue;
   logic [scm_pkg::PEAK_W-1:0] mag_l, mag_r, peak_now;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign start    = ~busy_ff & ~q_status.empty;
   assign pop      = start;
   assign finish   = busy_ff & (step_ff == ST_DONE) & out_free;
   assign issue    = busy_ff & (step_ff != ST_DONE);

   always_comb begin
      case (step_ff)
         ST_A_L: begin
            mul_a = ACC_W'(item_ff.deck_a_left);
            mul_b = MB_W'({1'b0, item_ff.gain_a});
         end
         ST_B_L: begin
            mul_a = ACC_W'(item_ff.deck_b_left);
            mul_b = MB_W'({1'b0, item_ff.gain_b});
         end
         ST_A_R: begin
            mul_a = ACC_W'(item_ff.deck_a_right);
            mul_b = MB_W'({1'b0, item_ff.gain_a});
         end
         ST_B_R: begin
            mul_a = ACC_W'(item_ff.deck_b_right);
            mul_b = MB_W'({1'b0, item_ff.gain_b});
         end
         ST_MIX_L: begin
            mul_a = acc_l_ff;
            mul_b = MB_W'({1'b0, item_ff.main_vol});
         end
         ST_MIX_R: begin
            mul_a = acc_r_ff;
            mul_b = MB_W'({1'b0, item_ff.main_vol});
         end
         ST_CUE_L: begin
            mul_a = ACC_W'(item_ff.cue_in_left);
            mul_b = MB_W'({1'b0, item_ff.cue_vol});
         end
         ST_CUE_R: begin
            mul_a = ACC_W'(item_ff.cue_in_right);
            mul_b = MB_W'({1'b0, item_ff.cue_vol});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;

   // send returns enter at the same Q30 scale as the gained decks
   assign send_l = ACC_W'(item_ff.send_return_left) <<< scm_pkg::SEND_SHIFT;
   assign send_r = ACC_W'(item_ff.send_return_right) <<< scm_pkg::SEND_SHIFT;

   // master products retire at steps MIX_R and CUE_L, cue products after
   assign rounded = scm_pkg::round_sat(prod_ff,
                       (step_ff == ST_MIX_R) || (step_ff == ST_CUE_L));

   assign mag_l = scm_pkg::magnitude(main_l_ff);
   assign mag_r = scm_pkg::magnitude(main_r_ff);

   always_comb begin
      peak_now = peak_hold_ff;
      if (mag_l > peak_now) begin
         peak_now = mag_l;
      end
      if (mag_r > peak_now) begin
         peak_now = mag_r;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      peak_hold_in = peak_hold_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = ST_A_L;
      end else if (issue) begin
         step_in = step_ff + 4'd1;
      end else if (finish) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         peak_hold_in = item_ff.clear_peak ? '0 : peak_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_A_L;
         rsp_valid_ff <= 1'b0;
         peak_hold_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_hold_ff <= peak_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= head_item;
      end
      if (issue) begin
         prod_ff <= mul_out;
      end
      if (busy_ff) begin
         case (step_ff)
            ST_B_L:   acc_l_ff  <= prod_ff[ACC_W-1:0] + send_l;
            ST_A_R:   acc_l_ff  <= acc_l_ff + prod_ff[ACC_W-1:0];
            ST_B_R:   acc_r_ff  <= prod_ff[ACC_W-1:0] + send_r;
            ST_MIX_L: acc_r_ff  <= acc_r_ff + prod_ff[ACC_W-1:0];
            ST_MIX_R: main_l_ff <= rounded;
            ST_CUE_L: main_r_ff <= rounded;
            ST_CUE_R: cue_l_ff  <= rounded;
            default: ;
         endcase
      end
      if (finish) begin
         rsp_data_ff <= scm_pkg::OUT_DATA_W'({peak_now, rounded, cue_l_ff,
                                              main_r_ff, main_l_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/stereo_crossfade_mixer_core.sv */
// Stereo crossfade mixer: one input word carries a full stereo frame (two
// decks, cue pair, send return and a clear_peak flag); one output word
// carries the master pair, the cue pair and the running peak magnitude.
// The user is to set registers through the csr_ port only while the block
// is idle; the block itself does not enforce this. The gain table read is
// registered at the same edge as the position register. The front takes a
// word whenever the two-entry queue has room. The back pulls one frame,
// runs eight products through a single shared multiplier (one per cycle,
// result registered) and loads the output register. A frame holds the back
// through a pull step, eight product steps and a retire step, and it pulls
// the next frame only after the retire step has raised rsp_tvalid.
// When rsp_tready is held low the finished word waits in the output
// register, the back holds its last step, the queue fills and then
// req_tready drops. Reset restores the register defaults, empties the
// queue, clears the peak hold and drops rsp_tvalid.
module stereo_crossfade_mixer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [scm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [scm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // deck_a_left, deck_a_right, deck_b_left, deck_b_right, cue_in_left,
   // cue_in_right, send_return_left, send_return_right, clear_peak, zero pad
   input  logic [scm_pkg::IN_DATA_W-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // main_left, main_right, cue_out_left, cue_out_right, peak_now
   output logic [scm_pkg::OUT_DATA_W-1:0]  rsp_tdata
);

   scm_pkg::queue_status_type q_status;
   scm_pkg::item_type         push_item;
   scm_pkg::item_type         head_item;
   logic                      push;
   logic                      pop;

   scm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   scm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   scm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/scm_checker.sv */
`include "stereo_crossfade_mixer_core_assert.svh"

module scm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [scm_pkg::OUT_DATA_W-1:0]  rsp_tdata
);

   localparam int SW = scm_pkg::SAMPLE_WIDTH;
   // queue entries plus the frame in the back plus the output register
   localparam logic [2:0] MAX_PENDING = 3'(scm_pkg::QUEUE_DEPTH + 2);

   logic [2:0] pending_ff, pending_in;
   logic       in_acc, out_acc;
   logic [scm_pkg::PEAK_W-1:0] mag_l, mag_r, peak;

   assign in_acc  = req_tvalid & req_tready;
   assign out_acc = rsp_tvalid & rsp_tready;

   always_comb begin
      case ({in_acc, out_acc})
         2'b10:   pending_in = pending_ff + 3'd1;
         2'b01:   pending_in = pending_ff - 3'd1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assign mag_l = scm_pkg::magnitude(rsp_tdata[0 +: SW]);
   assign mag_r = scm_pkg::magnitude(rsp_tdata[SW +: SW]);
   assign peak  = rsp_tdata[4*SW +: scm_pkg::PEAK_W];

   `SCM_ASSERT_ALWAYS(a_no_orphan_word, clock, reset, !rsp_tvalid || (pending_ff != 3'd0))
   `SCM_ASSERT_ALWAYS(a_pending_bound, clock, reset, pending_ff <= MAX_PENDING)
   `SCM_ASSERT_ALWAYS(a_peak_covers_mix, clock, reset, !rsp_tvalid || (peak >= mag_l && peak >= mag_r))
   `SCM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind stereo_crossfade_mixer_core scm_checker u_scm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
